// ===== rtl/arpc_pkg.sv =====
// Shared constants, codes and types for the ARP cache and resolver.
package arpc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int CACHE_ENTRIES_DEF   = 16;
  localparam int TRACKER_ENTRIES_DEF = 8;
  localparam int TIME_BITS_DEF       = 32;

  // Field widths fixed by the interface.
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int KIND_W  = 3;
  localparam int SENT_W  = 4;
  localparam int CFG_IDX_W = 3;

  // ARP header values that a received word must carry.
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [7:0]  MAC_BYTES   = 8'd6;
  localparam logic [7:0]  IPV4_BYTES  = 8'd4;
  localparam logic [15:0] OPC_REQUEST = 16'd1;
  localparam logic [15:0] OPC_REPLY   = 16'd2;

  localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

  // Operation codes of an input word.
  localparam logic [1:0] OPER_TICK    = 2'd0;
  localparam logic [1:0] OPER_PACKET  = 2'd1;
  localparam logic [1:0] OPER_RESOLVE = 2'd2;
  localparam logic [1:0] OPER_UNUSED  = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REQUEST  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESOLVED = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PENDING  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FAILED   = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INTERFACE_IP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERFACE_MAC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIFE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_WAIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT = 3'd4;

  // Control states of the top level.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// ===== rtl/arpc_cell.sv =====
// One table cell: holds an entry and folds it into the search word passed along the row.
module arpc_cell #(
  parameter int KW  = 32,
  parameter int DW  = 48,
  parameter int TW  = 32,
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [KW-1:0] key,
  input  logic [TW-1:0] now,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  logic          wr_valid,
  input  logic [KW-1:0] wr_key,
  input  logic [DW-1:0] wr_data,
  input  logic [TW-1:0] wr_stamp,
  input  logic          hit_i,
  input  logic [IW-1:0] hit_idx_i,
  input  logic [DW-1:0] hit_data_i,
  input  logic [TW-1:0] hit_stamp_i,
  input  logic          free_i,
  input  logic [IW-1:0] free_idx_i,
  input  logic [TW-1:0] old_age_i,
  input  logic [IW-1:0] old_idx_i,
  output logic          hit_o,
  output logic [IW-1:0] hit_idx_o,
  output logic [DW-1:0] hit_data_o,
  output logic [TW-1:0] hit_stamp_o,
  output logic          free_o,
  output logic [IW-1:0] free_idx_o,
  output logic [TW-1:0] old_age_o,
  output logic [IW-1:0] old_idx_o
);

  logic          valid;
  logic [KW-1:0] ekey;
  logic [DW-1:0] data;
  logic [TW-1:0] stamp;
  logic [TW-1:0] age;
  logic          my_hit;
  logic          take_old;

  // Entry storage, written by the controller at this cell's index.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en && (wr_idx == IW'(IDX))) begin
      valid <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IW'(IDX))) begin
      ekey  <= wr_key;
      data  <= wr_data;
      stamp <= wr_stamp;
    end
  end

  // Compare against the key and against the oldest entry seen so far.
  assign age      = now - stamp;
  assign my_hit   = valid && (ekey == key);
  assign take_old = (IDX == 0) || (age > old_age_i);

  // The search word moves one cell further in every cycle.
  always_ff @(posedge clk) begin
    hit_o       <= hit_i | my_hit;
    hit_idx_o   <= hit_i ? hit_idx_i   : IW'(IDX);
    hit_data_o  <= hit_i ? hit_data_i  : data;
    hit_stamp_o <= hit_i ? hit_stamp_i : stamp;
    free_o      <= free_i | !valid;
    free_idx_o  <= free_i ? free_idx_i : IW'(IDX);
    old_age_o   <= take_old ? age : old_age_i;
    old_idx_o   <= take_old ? IW'(IDX) : old_idx_i;
  end

endmodule

// ===== rtl/arpc_chain.sv =====
// A row of table cells with a shared write port and the search result at its far end.
module arpc_chain #(
  parameter int N  = 16,
  parameter int KW = 32,
  parameter int DW = 48,
  parameter int TW = 32,
  parameter int IW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [KW-1:0] key,
  input  logic [TW-1:0] now,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  logic          wr_valid,
  input  logic [KW-1:0] wr_key,
  input  logic [DW-1:0] wr_data,
  input  logic [TW-1:0] wr_stamp,
  output logic          hit,
  output logic [IW-1:0] hit_idx,
  output logic [DW-1:0] hit_data,
  output logic [TW-1:0] hit_stamp,
  output logic          free,
  output logic [IW-1:0] free_idx,
  output logic [IW-1:0] old_idx
);

  logic          c_hit      [N+1];
  logic [IW-1:0] c_hit_idx  [N+1];
  logic [DW-1:0] c_hit_data [N+1];
  logic [TW-1:0] c_hit_stamp[N+1];
  logic          c_free     [N+1];
  logic [IW-1:0] c_free_idx [N+1];
  logic [TW-1:0] c_old_age  [N+1];
  logic [IW-1:0] c_old_idx  [N+1];

  // The head of the row starts with an empty search word.
  assign c_hit[0]       = 1'b0;
  assign c_hit_idx[0]   = '0;
  assign c_hit_data[0]  = '0;
  assign c_hit_stamp[0] = '0;
  assign c_free[0]      = 1'b0;
  assign c_free_idx[0]  = '0;
  assign c_old_age[0]   = '0;
  assign c_old_idx[0]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    arpc_cell #(
      .KW(KW), .DW(DW), .TW(TW), .IW(IW), .IDX(i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .key        (key),
      .now        (now),
      .wr_en      (wr_en),
      .wr_idx     (wr_idx),
      .wr_valid   (wr_valid),
      .wr_key     (wr_key),
      .wr_data    (wr_data),
      .wr_stamp   (wr_stamp),
      .hit_i      (c_hit[i]),
      .hit_idx_i  (c_hit_idx[i]),
      .hit_data_i (c_hit_data[i]),
      .hit_stamp_i(c_hit_stamp[i]),
      .free_i     (c_free[i]),
      .free_idx_i (c_free_idx[i]),
      .old_age_i  (c_old_age[i]),
      .old_idx_i  (c_old_idx[i]),
      .hit_o      (c_hit[i+1]),
      .hit_idx_o  (c_hit_idx[i+1]),
      .hit_data_o (c_hit_data[i+1]),
      .hit_stamp_o(c_hit_stamp[i+1]),
      .free_o     (c_free[i+1]),
      .free_idx_o (c_free_idx[i+1]),
      .old_age_o  (c_old_age[i+1]),
      .old_idx_o  (c_old_idx[i+1])
    );
  end

  assign hit       = c_hit[N];
  assign hit_idx   = c_hit_idx[N];
  assign hit_data  = c_hit_data[N];
  assign hit_stamp = c_hit_stamp[N];
  assign free      = c_free[N];
  assign free_idx  = c_free_idx[N];
  assign old_idx   = c_old_idx[N];

endmodule

// ===== rtl/arp_cache_resolver_core.sv =====
// ARP cache and resolver top level: controller, time counter and the two cell rows.
//
//  channel  | handshake            | contents
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_stall  | operation and ARP packet fields, resolve_ip
//  out      | out_valid / out_stall| result_kind, peer_ip, peer_mac
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A result is registered once the scan counter reaches the length of the longer row after its word
// is accepted, and the next word is accepted only once the block is back in idle, so a new word
// is not taken while one is in flight. The search word walks the cache row and the tracker row one cell per cycle.
// A result waiting under out_stall holds the finished search until the output frees.
// Reset clears all valid bits, the time counter, the state and out_valid, and loads the configuration defaults.
module arp_cache_resolver_core #(
  parameter int CACHE_ENTRIES   = arpc_pkg::CACHE_ENTRIES_DEF,
  parameter int TRACKER_ENTRIES = arpc_pkg::TRACKER_ENTRIES_DEF,
  parameter int TIME_BITS       = arpc_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] hw_type,
  input  logic [15:0] proto_type,
  input  logic [7:0]  hw_len,
  input  logic [7:0]  proto_len,
  input  logic [15:0] arp_opcode,
  input  logic [31:0] sender_ip,
  input  logic [47:0] sender_mac,
  input  logic [31:0] target_ip,
  input  logic [31:0] resolve_ip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [31:0] peer_ip,
  output logic [47:0] peer_mac,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int CIW      = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int TIW      = (TRACKER_ENTRIES > 1) ? $clog2(TRACKER_ENTRIES) : 1;
  localparam int SCAN_LEN = (CACHE_ENTRIES > TRACKER_ENTRIES) ? CACHE_ENTRIES
                                                               : TRACKER_ENTRIES;
  localparam int CNT_W    = $clog2(SCAN_LEN + 1);
  localparam int AW       = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int IPW      = arpc_pkg::IP_W;
  localparam int MW       = arpc_pkg::MAC_W;
  localparam int SW       = arpc_pkg::SENT_W;

  arpc_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             finish;

  // Captured input word.
  logic [1:0]     op_q;
  logic           pkt_ok_q;
  logic [15:0]    opcode_q;
  logic [IPW-1:0] sip_q;
  logic [MW-1:0]  smac_q;
  logic [IPW-1:0] tip_q;
  logic [IPW-1:0] key_q;

  // Configuration registers. The interface MAC is only used in frame building,
  // which lives outside this block, so its writes are taken and dropped.
  logic [IPW-1:0] interface_ip;
  logic [15:0]    entry_lifetime;
  logic [7:0]     retry_wait;
  logic [SW-1:0]  request_limit;

  logic [TIME_BITS-1:0] now;

  // Search results at the end of each row.
  logic                 c_hit, c_free;
  logic [CIW-1:0]       c_hit_idx, c_free_idx, c_old_idx;
  logic [MW-1:0]        c_hit_data;
  logic [TIME_BITS-1:0] c_hit_stamp;
  logic                 t_hit, t_free;
  logic [TIW-1:0]       t_hit_idx, t_free_idx, t_old_idx;
  logic [SW-1:0]        t_hit_data;
  logic [TIME_BITS-1:0] t_hit_stamp;

  // Decision outputs.
  logic                 c_wr_en, c_wr_valid;
  logic [CIW-1:0]       c_wr_idx;
  logic                 t_wr_en, t_wr_valid;
  logic [TIW-1:0]       t_wr_idx;
  logic [SW-1:0]        t_wr_data;
  logic [TIME_BITS-1:0] t_wr_stamp;
  logic [2:0]           res_kind;
  logic [IPW-1:0]       res_ip;
  logic [MW-1:0]        res_mac;

  assign accept    = in_valid && !in_stall;
  assign finish    = (state == arpc_pkg::ST_SCAN) && (cnt == CNT_W'(SCAN_LEN))
                     && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      arpc_pkg::ST_IDLE: if (accept) state_next = arpc_pkg::ST_SCAN;
      arpc_pkg::ST_SCAN: if (finish) state_next = arpc_pkg::ST_IDLE;
      default:           state_next = arpc_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    case (state)
      arpc_pkg::ST_IDLE: in_stall = 1'b0;
      default:           in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arpc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if ((state == arpc_pkg::ST_SCAN) && (cnt != CNT_W'(SCAN_LEN))) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Capture the input word; the search key stays put for the whole scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= operation;
      pkt_ok_q <= (hw_type == arpc_pkg::HW_ETHERNET)
                  && (proto_type == arpc_pkg::PROTO_IPV4)
                  && (hw_len == arpc_pkg::MAC_BYTES)
                  && (proto_len == arpc_pkg::IPV4_BYTES);
      opcode_q <= arp_opcode;
      sip_q    <= sender_ip;
      smac_q   <= sender_mac;
      tip_q    <= target_ip;
      key_q    <= (operation == arpc_pkg::OPER_RESOLVE) ? resolve_ip : sender_ip;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      interface_ip   <= '0;
      entry_lifetime <= 16'd15;
      retry_wait     <= 8'd1;
      request_limit  <= 4'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arpc_pkg::REG_INTERFACE_IP:  interface_ip   <= cfg_data[IPW-1:0];
        arpc_pkg::REG_ENTRY_LIFE:    entry_lifetime <= cfg_data[15:0];
        arpc_pkg::REG_RETRY_WAIT:    retry_wait     <= cfg_data[7:0];
        arpc_pkg::REG_REQUEST_LIMIT: request_limit  <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // Seconds counter, advanced when a tick word completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
    end else if (finish && (op_q == arpc_pkg::OPER_TICK)) begin
      now <= now + 1'b1;
    end
  end

  arpc_chain #(
    .N(CACHE_ENTRIES), .KW(IPW), .DW(MW), .TW(TIME_BITS), .IW(CIW)
  ) u_cache (
    .clk      (clk),
    .rst      (rst),
    .key      (key_q),
    .now      (now),
    .wr_en    (c_wr_en),
    .wr_idx   (c_wr_idx),
    .wr_valid (c_wr_valid),
    .wr_key   (key_q),
    .wr_data  (smac_q),
    .wr_stamp (now),
    .hit      (c_hit),
    .hit_idx  (c_hit_idx),
    .hit_data (c_hit_data),
    .hit_stamp(c_hit_stamp),
    .free     (c_free),
    .free_idx (c_free_idx),
    .old_idx  (c_old_idx)
  );

  arpc_chain #(
    .N(TRACKER_ENTRIES), .KW(IPW), .DW(SW), .TW(TIME_BITS), .IW(TIW)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .key      (key_q),
    .now      (now),
    .wr_en    (t_wr_en),
    .wr_idx   (t_wr_idx),
    .wr_valid (t_wr_valid),
    .wr_key   (key_q),
    .wr_data  (t_wr_data),
    .wr_stamp (t_wr_stamp),
    .hit      (t_hit),
    .hit_idx  (t_hit_idx),
    .hit_data (t_hit_data),
    .hit_stamp(t_hit_stamp),
    .free     (t_free),
    .free_idx (t_free_idx),
    .old_idx  (t_old_idx)
  );

  // Decide the result and the table updates once the search word is complete.
  always_comb begin
    logic [TIME_BITS-1:0] c_age;
    logic [TIME_BITS-1:0] t_age;
    logic [SW-1:0]        sent;
    logic [TIME_BITS-1:0] tstamp;
    logic [TIW-1:0]       tslot;

    c_age  = now - c_hit_stamp;
    tslot  = t_hit ? t_hit_idx : (t_free ? t_free_idx : t_old_idx);
    sent   = t_hit ? t_hit_data : '0;
    tstamp = t_hit ? t_hit_stamp : now;
    t_age  = now - tstamp;

    c_wr_en    = 1'b0;
    c_wr_idx   = c_hit ? c_hit_idx : (c_free ? c_free_idx : c_old_idx);
    c_wr_valid = 1'b1;
    t_wr_en    = 1'b0;
    t_wr_idx   = tslot;
    t_wr_valid = 1'b0;
    t_wr_data  = sent + 1'b1;
    t_wr_stamp = now;
    res_kind   = arpc_pkg::KIND_NONE;
    res_ip     = '0;
    res_mac    = '0;

    case (op_q)
      arpc_pkg::OPER_PACKET: begin
        if (pkt_ok_q) begin
          // Refresh a known sender; add it when the packet is for us.
          c_wr_en = c_hit || (tip_q == interface_ip);
          if (tip_q == interface_ip) begin
            if (opcode_q == arpc_pkg::OPC_REQUEST) begin
              res_kind = arpc_pkg::KIND_REPLY;
              res_ip   = sip_q;
              res_mac  = smac_q;
            end else if (opcode_q == arpc_pkg::OPC_REPLY) begin
              t_wr_en    = t_hit;
              t_wr_idx   = t_hit_idx;
              t_wr_valid = 1'b0;
              res_kind   = arpc_pkg::KIND_RELEASE;
              res_ip     = sip_q;
              res_mac    = smac_q;
            end
          end
        end
      end
      arpc_pkg::OPER_RESOLVE: begin
        res_ip = key_q;
        if (c_hit && (AW'(c_age) < AW'(entry_lifetime))) begin
          res_kind = arpc_pkg::KIND_RESOLVED;
          res_mac  = c_hit_data;
        end else begin
          // Drop a stale entry, then work the retry tracker.
          c_wr_en    = c_hit;
          c_wr_idx   = c_hit_idx;
          c_wr_valid = 1'b0;
          if (sent >= request_limit) begin
            t_wr_en    = 1'b1;
            t_wr_valid = 1'b0;
            res_kind   = arpc_pkg::KIND_FAILED;
          end else if ((sent == '0) || (AW'(t_age) >= AW'(retry_wait))) begin
            t_wr_en    = 1'b1;
            t_wr_valid = 1'b1;
            res_kind   = arpc_pkg::KIND_REQUEST;
            res_mac    = arpc_pkg::MAC_BROADCAST;
          end else begin
            res_kind = arpc_pkg::KIND_PENDING;
          end
        end
      end
      default: ;
    endcase

    c_wr_en = c_wr_en && finish;
    t_wr_en = t_wr_en && finish;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_kind <= res_kind;
      peer_ip     <= res_ip;
      peer_mac    <= res_mac;
    end
  end

endmodule

// ===== sim/tb_arp_cache_resolver_core.sv =====
// Self-checking testbench for the ARP cache and resolver core.
`timescale 1ns / 1ps

module tb_arp_cache_resolver_core;

  localparam int NCACHE = 16;
  localparam int NTRACK = 8;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]  oper;
    logic [15:0] htype;
    logic [15:0] ptype;
    logic [7:0]  hlen;
    logic [7:0]  plen;
    logic [15:0] opc;
    logic [31:0] sip;
    logic [47:0] smac;
    logic [31:0] tip;
    logic [31:0] rip;
  } arp_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] ip;
    logic [47:0] mac;
  } arp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = '0;
  logic [15:0] hw_type = '0;
  logic [15:0] proto_type = '0;
  logic [7:0] hw_len = '0;
  logic [7:0] proto_len = '0;
  logic [15:0] arp_opcode = '0;
  logic [31:0] sender_ip = '0;
  logic [47:0] sender_mac = '0;
  logic [31:0] target_ip = '0;
  logic [31:0] resolve_ip = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] result_kind;
  logic [31:0] peer_ip;
  logic [47:0] peer_mac;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  arp_cache_resolver_core uut (.*);

  // Shadow copy of the block's registers and tables.
  logic [31:0] my_ip;
  logic [15:0] lifetime;
  logic [7:0]  wait_s;
  logic [3:0]  req_limit;
  logic [31:0] clock_s;
  logic        c_ok [NCACHE];
  logic [31:0] c_ip [NCACHE];
  logic [47:0] c_mac [NCACHE];
  logic [31:0] c_stamp [NCACHE];
  logic        t_ok [NTRACK];
  logic [31:0] t_ip [NTRACK];
  logic [3:0]  t_sent [NTRACK];
  logic [31:0] t_stamp [NTRACK];

  arp_result_t expected_results[$];
  int mismatches = 0;
  bit failed = 1'b0;
  int cycles = 0;
  logic [31:0] peers[8];

  initial forever #5 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Drive stall at random at the falling edge, with quiet stretches.
  int stall_left = 0;
  bit stall_calm = 1'b0;
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_calm <= ~stall_calm;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!stall_calm && $urandom_range(0, 3) == 0) stall_left <= $urandom_range(0, 11);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    arp_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind %0d ip %h", result_kind, peer_ip);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.kind !== result_kind || exp_r.ip !== peer_ip || exp_r.mac !== peer_mac) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %h %h got %0d %h %h", exp_r.kind, exp_r.ip,
                     exp_r.mac, result_kind, peer_ip, peer_mac);
        end
      end
    end
  end

  function automatic int find_cache(logic [31:0] ip);
    for (int i = 0; i < NCACHE; i++) if (c_ok[i] && c_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int oldest_cache();
    int pick;
    logic [31:0] best;
    pick = 0;
    best = 0;
    for (int i = 0; i < NCACHE; i++) if (!c_ok[i]) return i;
    for (int i = 0; i < NCACHE; i++)
      if (i == 0 || clock_s - c_stamp[i] > best) begin
        best = clock_s - c_stamp[i];
        pick = i;
      end
    return pick;
  endfunction

  function automatic int find_tracker(logic [31:0] ip);
    for (int i = 0; i < NTRACK; i++) if (t_ok[i] && t_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int oldest_tracker();
    int pick;
    logic [31:0] best;
    pick = 0;
    best = 0;
    for (int i = 0; i < NTRACK; i++) if (!t_ok[i]) return i;
    for (int i = 0; i < NTRACK; i++)
      if (i == 0 || clock_s - t_stamp[i] > best) begin
        best = clock_s - t_stamp[i];
        pick = i;
      end
    return pick;
  endfunction

  // Work out the result of one word and update the shadow state.
  function automatic arp_result_t resolve_outcome(arp_word_t w);
    arp_result_t r;
    int e;
    int t;
    r = '0;
    if (w.oper == arpc_pkg::OPER_TICK) begin
      clock_s = clock_s + 1;
    end else if (w.oper == arpc_pkg::OPER_PACKET) begin
      if (w.htype == arpc_pkg::HW_ETHERNET && w.hlen == arpc_pkg::MAC_BYTES &&
          w.ptype == arpc_pkg::PROTO_IPV4 && w.plen == arpc_pkg::IPV4_BYTES) begin
        e = find_cache(w.sip);
        if (e >= 0) begin
          c_mac[e] = w.smac;
          c_stamp[e] = clock_s;
        end
        if (w.tip == my_ip) begin
          if (e < 0) begin
            e = oldest_cache();
            c_ok[e] = 1'b1;
            c_ip[e] = w.sip;
            c_mac[e] = w.smac;
            c_stamp[e] = clock_s;
          end
          if (w.opc == arpc_pkg::OPC_REQUEST) begin
            r = '{arpc_pkg::KIND_REPLY, w.sip, w.smac};
          end else if (w.opc == arpc_pkg::OPC_REPLY) begin
            t = find_tracker(w.sip);
            if (t >= 0) t_ok[t] = 1'b0;
            r = '{arpc_pkg::KIND_RELEASE, w.sip, w.smac};
          end
        end
      end
    end else if (w.oper == arpc_pkg::OPER_RESOLVE) begin
      e = find_cache(w.rip);
      if (e >= 0 && clock_s - c_stamp[e] < {16'd0, lifetime}) begin
        r = '{arpc_pkg::KIND_RESOLVED, w.rip, c_mac[e]};
      end else begin
        if (e >= 0) c_ok[e] = 1'b0;
        t = find_tracker(w.rip);
        if (t < 0) begin
          t = oldest_tracker();
          t_ok[t] = 1'b1;
          t_ip[t] = w.rip;
          t_sent[t] = 0;
          t_stamp[t] = clock_s;
        end
        if (t_sent[t] >= req_limit) begin
          t_ok[t] = 1'b0;
          r = '{arpc_pkg::KIND_FAILED, w.rip, 48'd0};
        end else if (t_sent[t] == 0 || clock_s - t_stamp[t] >= {24'd0, wait_s}) begin
          t_sent[t] = t_sent[t] + 1;
          t_stamp[t] = clock_s;
          r = '{arpc_pkg::KIND_REQUEST, w.rip, arpc_pkg::MAC_BROADCAST};
        end else begin
          r = '{arpc_pkg::KIND_PENDING, w.rip, 48'd0};
        end
      end
    end
    return r;
  endfunction

  // Send one word after a random gap; predict at acceptance. Entered at a falling edge.
  task automatic send_word(arp_word_t w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    {operation, hw_type, proto_type, hw_len, proto_len, arp_opcode, sender_ip, sender_mac,
     target_ip, resolve_ip} <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(resolve_outcome(w));
    @(negedge clk);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      arpc_pkg::REG_INTERFACE_IP:  my_ip = val[31:0];
      arpc_pkg::REG_ENTRY_LIFE:    lifetime = val[15:0];
      arpc_pkg::REG_RETRY_WAIT:    wait_s = val[7:0];
      arpc_pkg::REG_REQUEST_LIMIT: req_limit = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop the input and wait for every expected result; entered at a falling edge.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic arp_word_t random_word();
    logic [223:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return noise[$bits(arp_word_t)-1:0];
  endfunction

  function automatic arp_word_t good_packet(logic [15:0] opc, logic [31:0] sip,
                                            logic [47:0] smac, logic [31:0] tip);
    arp_word_t w;
    w = '0;
    w.oper = arpc_pkg::OPER_PACKET;
    w.htype = arpc_pkg::HW_ETHERNET;
    w.ptype = arpc_pkg::PROTO_IPV4;
    w.hlen = arpc_pkg::MAC_BYTES;
    w.plen = arpc_pkg::IPV4_BYTES;
    w.opc = opc;
    w.sip = sip;
    w.smac = smac;
    w.tip = tip;
    return w;
  endfunction

  function automatic arp_word_t resolve_word(logic [31:0] ip);
    arp_word_t w;
    w = random_word();
    w.oper = arpc_pkg::OPER_RESOLVE;
    w.rip = ip;
    return w;
  endfunction

  function automatic arp_word_t tick_word();
    arp_word_t w;
    w = random_word();
    w.oper = arpc_pkg::OPER_TICK;
    return w;
  endfunction

  // Directed: header extremes, each opcode, expiry, retry and failure, unknown operation.
  task automatic test_directed();
    arp_word_t w;
    write_reg(arpc_pkg::REG_INTERFACE_IP, 48'hFFFF_FFFF);
    write_reg(arpc_pkg::REG_INTERFACE_MAC, 48'hFFFF_FFFF_FFFF);
    write_reg(arpc_pkg::REG_ENTRY_LIFE, 48'd2);
    write_reg(arpc_pkg::REG_RETRY_WAIT, 48'd0);
    write_reg(arpc_pkg::REG_REQUEST_LIMIT, 48'd2);
    send_word(good_packet(arpc_pkg::OPC_REQUEST, 32'h0, 48'h0, 32'hFFFF_FFFF));
    send_word(good_packet(arpc_pkg::OPC_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                          32'hFFFF_FFFF));
    send_word(good_packet(16'hFFFF, 32'h1234, 48'h1, 32'hFFFF_FFFF));
    send_word(good_packet(arpc_pkg::OPC_REQUEST, 32'h5, 48'h5, 32'h0));
    w = good_packet(arpc_pkg::OPC_REQUEST, 32'h6, 48'h6, 32'hFFFF_FFFF);
    w.htype = 16'hFFFF;
    send_word(w);
    w = good_packet(arpc_pkg::OPC_REQUEST, 32'h6, 48'h6, 32'hFFFF_FFFF);
    w.hlen = 8'hFF;
    send_word(w);
    w = good_packet(arpc_pkg::OPC_REQUEST, 32'h6, 48'h6, 32'hFFFF_FFFF);
    w.ptype = 16'h0;
    send_word(w);
    w = good_packet(arpc_pkg::OPC_REQUEST, 32'h6, 48'h6, 32'hFFFF_FFFF);
    w.plen = 8'h0;
    send_word(w);
    send_word(resolve_word(32'h0));
    send_word(tick_word());
    send_word(tick_word());
    send_word(resolve_word(32'h0));
    send_word(resolve_word(32'h0));
    send_word(resolve_word(32'h0));
    send_word(resolve_word(32'h0));
    w = tick_word();
    w.oper = arpc_pkg::OPER_UNUSED;
    send_word(w);
    drain();
    write_reg(arpc_pkg::REG_ENTRY_LIFE, 48'd0);
    write_reg(arpc_pkg::REG_REQUEST_LIMIT, 48'd0);
    send_word(resolve_word(32'hFFFF_FFFF));
    send_word(resolve_word(32'h77));
    drain();
  endtask

  // Random: mostly well-formed traffic on a small address pool, some noise.
  task automatic test_random(int count, logic [31:0] ip);
    arp_word_t w;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        w = tick_word();
      end else if (sel < 55) begin
        w = good_packet($urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2)),
                        peers[$urandom_range(0, 7)], 48'({$urandom, $urandom}),
                        $urandom_range(0, 3) == 0 ? $urandom : ip);
        if ($urandom_range(0, 99) < 30) w.sip = $urandom;
      end else if (sel < 90) begin
        w = resolve_word($urandom_range(0, 4) == 0 ? $urandom : peers[$urandom_range(0, 7)]);
      end else begin
        w = random_word();
      end
      send_word(w);
    end
    drain();
  endtask

  task automatic test_config_sweep();
    logic [31:0] ip;
    for (int ph = 0; ph < 4; ph++) begin
      ip = $urandom;
      foreach (peers[i]) peers[i] = $urandom;
      write_reg(arpc_pkg::REG_INTERFACE_IP, {16'd0, ip});
      write_reg(arpc_pkg::REG_INTERFACE_MAC, 48'({$urandom, $urandom}));
      write_reg(arpc_pkg::REG_ENTRY_LIFE, ph == 3 ? 48'd65535 : 48'($urandom_range(1, 20)));
      write_reg(arpc_pkg::REG_RETRY_WAIT, ph == 2 ? 48'd255 : 48'($urandom_range(0, 4)));
      write_reg(arpc_pkg::REG_REQUEST_LIMIT, ph == 1 ? 48'd15 : 48'($urandom_range(1, 6)));
      test_random(320, ip);
    end
  endtask

  initial begin
    my_ip = 0;
    lifetime = 15;
    wait_s = 1;
    req_limit = 5;
    clock_s = 0;
    for (int i = 0; i < NCACHE; i++) c_ok[i] = 1'b0;
    for (int i = 0; i < NTRACK; i++) t_ok[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_sweep();
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
